/* sv/gspa_pkg.sv */
// Shared types and constants for the growable slot pool allocator.
package gspa_pkg;

   localparam int CNT_W      = 9;
   localparam int SLOT_W     = 8;
   localparam int GRANT_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = RSP_DATA_W - (SLOT_W + 2 * CNT_W + GRANT_W);

   localparam logic FUNC_TAKE = 1'b0;
   localparam logic FUNC_GIVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_GIVE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL  = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_FULL,
      OP_GIVE,
      OP_GROW,
      OP_SCAN
   } op_type;

   typedef struct packed {
      logic [CNT_W-1:0] eff_cap;
      logic [CNT_W-1:0] step;
      logic             reload;
      logic [CNT_W-1:0] reload_prov;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   granted;
      logic [CNT_W-1:0]    taken;
      logic [CNT_W-1:0]    prov;
      logic [GRANT_W-1:0]  grants;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } bm_ctl_type;

endpackage

/* sv/gspa_bitmap.sv */
// Busy bitmap memory, one word per row, with per-row valid flags.
module gspa_bitmap
   import gspa_pkg::*;
#(
   parameter int NWORDS  = 8,
   parameter int WADDR_W = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  bm_ctl_type         ctl,
   input  logic [WADDR_W-1:0] rd_addr,
   input  logic [WADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0]  wr_data,
   output logic [WORD_W-1:0]  rd_data
);

   logic [WORD_W-1:0] bitmap_mem [NWORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_valid_ff;
   logic [NWORDS-1:0] valid_ff;
   logic [NWORDS-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= bitmap_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // a row never written since the last clear reads as all free
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* sv/gspa_ctrl.sv */
// Request sequencer: counters, read-modify-write of the bitmap, lowest-free scan.
module gspa_ctrl
   import gspa_pkg::*;
#(
   parameter int NWORDS  = 8,
   parameter int WADDR_W = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic               out_free,
   output logic               res_valid,
   output rsp_type            res,
   output bm_ctl_type         bm_ctl,
   output logic [WADDR_W-1:0] rd_addr,
   output logic [WADDR_W-1:0] wr_addr,
   output logic [WORD_W-1:0]  wr_data,
   input  logic [WORD_W-1:0]  rd_data
);

   localparam int SLOTX_W = WADDR_W + BIT_W;
   localparam int CMP_W   = SLOTX_W + CNT_W;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [CNT_W-1:0]    slot_ff, slot_in;
   logic [WADDR_W-1:0]  widx_ff, widx_in;
   logic [CNT_W-1:0]    prov_ff, prov_in;
   logic [CNT_W-1:0]    taken_ff, taken_in;
   logic [GRANT_W-1:0]  grants_ff, grants_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0]   granted_ff, granted_in;

   logic [WORD_W-1:0]   free_bits;
   logic [BIT_W-1:0]    free_pos;
   logic                found;
   logic                last_word;
   logic [BIT_W-1:0]    bit_sel;
   logic [WADDR_W-1:0]  slot_addr;
   logic [CNT_W:0]      step_sum;
   logic [CNT_W-1:0]    grow_next;

   // free slots of the word in hand that lie below the provisioned count
   always_comb begin
      logic [SLOTX_W-1:0] slot_num;
      free_pos = '0;
      for (int b = 0; b < WORD_W; b++) begin
         slot_num     = {widx_ff, BIT_W'(b)};
         free_bits[b] = (CMP_W'(slot_num) < CMP_W'(prov_ff)) && !rd_data[b];
      end
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            free_pos = BIT_W'(b);
         end
      end
      found     = |free_bits;
      last_word = (((CMP_W'(widx_ff) + CMP_W'(1)) << BIT_W) >= CMP_W'(prov_ff))
                  || (widx_ff == WADDR_W'(NWORDS - 1));
   end

   assign bit_sel   = slot_ff[BIT_W-1:0];
   assign slot_addr = WADDR_W'(slot_ff >> BIT_W);
   assign step_sum  = {1'b0, prov_ff} + {1'b0, cfg.step};
   assign grow_next = (step_sum > {1'b0, cfg.eff_cap}) ? cfg.eff_cap : step_sum[CNT_W-1:0];

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      slot_in    = slot_ff;
      widx_in    = widx_ff;
      prov_in    = prov_ff;
      taken_in   = taken_ff;
      grants_in  = grants_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      bm_ctl     = '0;
      rd_addr    = widx_ff;
      wr_addr    = slot_addr;
      wr_data    = rd_data;
      req_ready  = 1'b0;
      res_valid  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               slot_in    = CNT_W'(req_slot);
               granted_in = '0;
               status_in  = STATUS_OK;
               if (req_func == FUNC_GIVE) begin
                  op_in        = OP_GIVE;
                  rd_addr      = WADDR_W'(req_slot >> BIT_W);
                  bm_ctl.rd_en = 1'b1;
                  state_in     = S_CHECK;
               end else if (taken_ff >= cfg.eff_cap) begin
                  op_in     = OP_FULL;
                  status_in = STATUS_FULL;
                  state_in  = S_DONE;
               end else if (taken_ff >= prov_ff) begin
                  op_in        = OP_GROW;
                  slot_in      = prov_ff;
                  rd_addr      = WADDR_W'(prov_ff >> BIT_W);
                  bm_ctl.rd_en = 1'b1;
                  state_in     = S_CHECK;
               end else begin
                  op_in        = OP_SCAN;
                  widx_in      = '0;
                  rd_addr      = '0;
                  bm_ctl.rd_en = 1'b1;
                  state_in     = S_CHECK;
               end
            end
         end

         S_CHECK: begin
            case (op_ff)
               OP_GIVE: begin
                  if (slot_ff >= prov_ff || !rd_data[bit_sel]) begin
                     status_in = STATUS_BAD_GIVE;
                  end else begin
                     bm_ctl.wr_en = 1'b1;
                     wr_data      = rd_data & ~(WORD_W'(1) << bit_sel);
                     if (taken_ff != '0) begin
                        taken_in = taken_ff - CNT_W'(1);
                     end
                  end
                  state_in = S_DONE;
               end
               OP_GROW: begin
                  bm_ctl.wr_en = 1'b1;
                  wr_data      = rd_data | (WORD_W'(1) << bit_sel);
                  prov_in      = grow_next;
                  taken_in     = taken_ff + CNT_W'(1);
                  grants_in    = grants_ff + GRANT_W'(1);
                  granted_in   = SLOT_W'(slot_ff);
                  state_in     = S_DONE;
               end
               OP_SCAN: begin
                  if (found) begin
                     bm_ctl.wr_en = 1'b1;
                     wr_addr      = widx_ff;
                     wr_data      = rd_data | (WORD_W'(1) << free_pos);
                     taken_in     = taken_ff + CNT_W'(1);
                     grants_in    = grants_ff + GRANT_W'(1);
                     granted_in   = SLOT_W'({widx_ff, free_pos});
                     state_in     = S_DONE;
                  end else if (last_word) begin
                     status_in = STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     // advance to the next word
                     widx_in      = widx_ff + WADDR_W'(1);
                     rd_addr      = widx_ff + WADDR_W'(1);
                     bm_ctl.rd_en = 1'b1;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // reload the pool; grants are kept
      if (cfg.reload) begin
         prov_in      = cfg.reload_prov;
         taken_in     = '0;
         bm_ctl.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         prov_ff   <= '0;
         taken_ff  <= '0;
         grants_ff <= '0;
      end else begin
         state_ff  <= state_in;
         prov_ff   <= prov_in;
         taken_ff  <= taken_in;
         grants_ff <= grants_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      slot_ff    <= slot_in;
      widx_ff    <= widx_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   assign res.status  = status_ff;
   assign res.granted = granted_ff;
   assign res.taken   = taken_ff;
   assign res.prov    = prov_ff;
   assign res.grants  = grants_ff;

endmodule

/* sv/growable_slot_pool_allocator_core.sv */
// Growable slot pool allocator: top level with configuration registers and result register.
//
// Hands out slot indices one request at a time; the busy flags live in a bitmap memory of
// 32-slot words read one word per cycle. A take that finds the pool full skips the bitmap, a
// giveback or a take that grows the pool reads and rewrites one word, and a take that
// searches for the lowest free slot reads word after word until it finds one or reaches the
// last provisioned word, all set by the single bitmap read port. A finished result waits in
// the output register while the next request is taken. Writing initial_slots reloads the
// pool through per-word valid flags, so there is no clearing pass after reset or reload.
module growable_slot_pool_allocator_core
   import gspa_pkg::*;
#(
   parameter int MAX_SLOTS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SLOT_W-1:0]     req_tdata,   // [7:0] return_slot
   input  logic [0:0]            req_tuser,   // [0] func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] granted_slot, [16:8] slots_taken, [25:17] slots_provisioned,
   // [57:26] grant_total, [63:58] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser,   // [1:0] status
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CNT_W-1:0]      csr_wdata
);

   localparam int NWORDS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
   localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CAP_MAX = (MAX_SLOTS > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : MAX_SLOTS;
   localparam logic [CNT_W-1:0] CAP_MAX_C = CNT_W'(CAP_MAX);

   logic [CNT_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   step_ff;
   cfg_type            cfg;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               out_free;
   logic               res_valid;
   rsp_type            res;
   bm_ctl_type         bm_ctl;
   logic [WADDR_W-1:0] rd_addr;
   logic [WADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [WORD_W-1:0]  rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CNT_W'(256);
         step_ff <= CNT_W'(16);
      end else if (csr_we) begin
         case (csr_index)
            REG_CAPACITY: cap_ff  <= csr_wdata;
            REG_STEP:     step_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.eff_cap     = (cap_ff < CAP_MAX_C) ? cap_ff : CAP_MAX_C;
      cfg.step        = (step_ff == '0) ? CNT_W'(1) : step_ff;
      cfg.reload      = csr_we && (csr_index == REG_INITIAL);
      cfg.reload_prov = (csr_wdata < cfg.eff_cap) ? csr_wdata : cfg.eff_cap;
   end

   gspa_ctrl #(
      .NWORDS  (NWORDS),
      .WADDR_W (WADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_func  (req_tuser[0]),
      .req_slot  (req_tdata),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .bm_ctl    (bm_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   gspa_bitmap #(
      .NWORDS  (NWORDS),
      .WADDR_W (WADDR_W)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .ctl     (bm_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // hold the result beat until the sink takes it
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_data_ff.grants, rsp_data_ff.prov,
                        rsp_data_ff.taken, rsp_data_ff.granted};

`ifndef SYNTHESIS
   a_taken_within_pool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.taken <= rsp_data_ff.prov))
      else $error("taken count exceeds provisioned count");

   a_grant_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STATUS_OK) |-> (rsp_data_ff.granted == '0))
      else $error("slot granted on a failed request");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while the previous one is in progress");
`endif

endmodule
